// ===== hdl/qmix_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadrotor mixer package
// Shared widths, register indexes and the motor sign pattern.
// ----------------------------------------------------------------------------
package qmix_pkg;

  localparam int unsigned NumMotors = 4;
  localparam int unsigned InW       = 32;
  localparam int unsigned GainW     = 32;
  localparam int unsigned QuadW     = 40;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 40;
  localparam int unsigned ProdW     = 64;   // signed input times unsigned gain
  localparam int unsigned SumW      = 67;   // four products, no overflow
  localparam int unsigned SqW       = 32;   // clamped squared speed
  localparam int unsigned SpdW      = 16;
  localparam int unsigned DutyW     = 16;

  localparam logic [CfgIdxW-1:0] RegThrustGain = 3'd0;
  localparam logic [CfgIdxW-1:0] RegYawGain    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTiltGain   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLinCoef    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegQuadCoef   = 3'd4;

  // per motor: 1 means subtract yaw, roll, pitch term (bits 2,1,0)
  localparam logic [2:0] NegPat [NumMotors] = '{3'b111, 3'b010, 3'b100, 3'b001};

endpackage

// ===== hdl/quadrotor_motor_mixer_core.sv =====
// ----------------------------------------------------------------------------
// Quadrotor motor mixer core
// X-frame mixer: thrust and torques to four rotor speeds and duties.
// ----------------------------------------------------------------------------
// Usage: the command channel (in_valid/in_ready) carries thrust and the three
// body torques; the result channel (out_valid/out_ready) carries four duties,
// four speeds and a per-motor saturation mask. Gains and duty coefficients
// are written through cfg_we/cfg_idx/cfg_data while no transaction is in
// flight; unknown indexes are ignored.
// The pipeline is 22 register stages deep: one product stage, one mixing add,
// one clamp, a 16-step pipelined square root (one result bit per stage), and
// three duty stages (coefficients times speed, times speed again, add and
// saturate).
// Throughput is one transaction per cycle while the output is not stalled;
// the square root stage chain sets the depth.
// Reset clears all valid bits and all configuration registers to zero.
// When out_valid is high and out_ready is low the whole pipeline holds;
// in_ready then drops, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quadrotor_motor_mixer_core
  import qmix_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CfgIdxW-1:0]    cfg_idx,
  input  logic [CfgDataW-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [InW-1:0] thrust,
  input  logic signed [InW-1:0] roll_torque,
  input  logic signed [InW-1:0] pitch_torque,
  input  logic signed [InW-1:0] yaw_torque,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DutyW-1:0]      duty_front_right,
  output logic [DutyW-1:0]      duty_rear_right,
  output logic [DutyW-1:0]      duty_rear_left,
  output logic [DutyW-1:0]      duty_front_left,
  output logic [SpdW-1:0]       speed_one,
  output logic [SpdW-1:0]       speed_two,
  output logic [SpdW-1:0]       speed_three,
  output logic [SpdW-1:0]       speed_four,
  output logic [NumMotors-1:0]  saturated
);

  localparam int unsigned NStg = 22;

  logic [GainW-1:0] thrust_gain, yaw_gain, tilt_gain, lin_coef;
  logic [QuadW-1:0] quad_coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      thrust_gain <= '0;
      yaw_gain    <= '0;
      tilt_gain   <= '0;
      lin_coef    <= '0;
      quad_coef   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegThrustGain: thrust_gain <= cfg_data[GainW-1:0];
        RegYawGain:    yaw_gain    <= cfg_data[GainW-1:0];
        RegTiltGain:   tilt_gain   <= cfg_data[GainW-1:0];
        RegLinCoef:    lin_coef    <= cfg_data[GainW-1:0];
        RegQuadCoef:   quad_coef   <= cfg_data[QuadW-1:0];
        default: ;
      endcase
    end
  end

  logic [NStg-1:0] vld;
  logic            adv;
  assign adv      = out_ready || !vld[NStg-1];
  assign in_ready = adv;
  assign out_valid = vld[NStg-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NStg-2:0], in_valid};
  end

  // stage 0: products
  logic signed [ProdW-1:0] pt, pr, pp, py;
  always_ff @(posedge clk) begin
    if (adv) begin
      pt <= ProdW'(thrust) * ProdW'($signed({1'b0, thrust_gain}));
      pr <= ProdW'(roll_torque) * ProdW'($signed({1'b0, tilt_gain}));
      pp <= ProdW'(pitch_torque) * ProdW'($signed({1'b0, tilt_gain}));
      py <= ProdW'(yaw_torque) * ProdW'($signed({1'b0, yaw_gain}));
    end
  end

  // stage 1: mix sums per motor
  logic signed [SumW-1:0] mix [NumMotors];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NumMotors; k++) begin
        mix[k] <= SumW'(pt)
          + (NegPat[k][2] ? -SumW'(py) : SumW'(py))
          + (NegPat[k][1] ? -SumW'(pr) : SumW'(pr))
          + (NegPat[k][0] ? -SumW'(pp) : SumW'(pp));
      end
    end
  end

  // stage 2: clamp to 32-bit squared speed
  logic [SqW-1:0] sq0 [NumMotors];
  logic [NumMotors-1:0] sat0;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NumMotors; k++) begin
        if (mix[k][SumW-1]) begin
          sq0[k]  <= '0;
          sat0[k] <= 1'b0;
        end else if (mix[k][SumW-2:24+SqW] != '0) begin
          sq0[k]  <= '1;
          sat0[k] <= 1'b1;
        end else begin
          sq0[k]  <= mix[k][24+SqW-1:24];
          sat0[k] <= 1'b0;
        end
      end
    end
  end

  // stages 3..18: square root, one bit per stage (restoring, on squares)
  logic [SqW-1:0]       rv  [SpdW][NumMotors];
  logic [SpdW-1:0]      rr  [SpdW+1][NumMotors];
  logic [NumMotors-1:0] rs  [SpdW+1];
  always_comb begin
    for (int k = 0; k < NumMotors; k++) begin
      rv[0][k] = sq0[k];
      rr[0][k] = '0;
    end
    rs[0] = sat0;
  end

  for (genvar b = 0; b < SpdW; b++) begin : g_root
    localparam int unsigned Bit = SpdW - 1 - b;
    always_ff @(posedge clk) begin
      if (adv) begin
        rs[b+1] <= rs[b];
        for (int k = 0; k < NumMotors; k++) begin
          logic [SpdW-1:0] t;
          logic [SqW-1:0]  t2;
          t  = rr[b][k] | SpdW'(1 << Bit);
          t2 = t * t;
          rr[b+1][k] <= (t2 <= rv[b][k]) ? t : rr[b][k];
        end
      end
    end
    // the last root stage no longer needs the radicand
    if (b < SpdW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int k = 0; k < NumMotors; k++) begin
            rv[b+1][k] <= rv[b][k];
          end
        end
      end
    end
  end

  // duty: coefficients times speed, times speed again, add and saturate
  logic [SpdW-1:0]       s_a  [NumMotors];
  logic [QuadW+SpdW-1:0] qs_a [NumMotors];
  logic [GainW+SpdW-1:0] l_a  [NumMotors];
  logic [NumMotors-1:0]  sat_a, sat_b;
  logic [SpdW-1:0]       s_b  [NumMotors];
  logic [QuadW+SqW-1:0]  q_b  [NumMotors];
  logic [GainW+SpdW-1:0] l_b  [NumMotors];
  logic [SpdW-1:0]       s_c  [NumMotors];
  logic [DutyW-1:0]      d_c  [NumMotors];
  logic [NumMotors-1:0]  sat_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      sat_a <= rs[SpdW];
      for (int k = 0; k < NumMotors; k++) begin
        s_a[k]  <= rr[SpdW][k];
        qs_a[k] <= (QuadW+SpdW)'(quad_coef) * (QuadW+SpdW)'(rr[SpdW][k]);
        l_a[k]  <= (GainW+SpdW)'(lin_coef) * (GainW+SpdW)'(rr[SpdW][k]);
      end
      sat_b <= sat_a;
      for (int k = 0; k < NumMotors; k++) begin
        s_b[k] <= s_a[k];
        q_b[k] <= (QuadW+SqW)'(qs_a[k]) * (QuadW+SqW)'(s_a[k]);
        l_b[k] <= l_a[k];
      end
      for (int k = 0; k < NumMotors; k++) begin
        logic [QuadW+SqW:0] tot;
        tot = (QuadW+SqW+1)'(q_b[k]) + (QuadW+SqW+1)'({l_b[k], 8'h00});
        s_c[k] <= s_b[k];
        if (tot[QuadW+SqW:QuadW] != '0) begin
          d_c[k]   <= '1;
          sat_c[k] <= 1'b1;
        end else begin
          d_c[k]   <= tot[QuadW-1:QuadW-DutyW];
          sat_c[k] <= sat_b[k];
        end
      end
    end
  end

  assign duty_front_right = d_c[0];
  assign duty_rear_right  = d_c[1];
  assign duty_rear_left   = d_c[2];
  assign duty_front_left  = d_c[3];
  assign speed_one        = s_c[0];
  assign speed_two        = s_c[1];
  assign speed_three      = s_c[2];
  assign speed_four       = s_c[3];
  assign saturated        = sat_c;

endmodule

// ===== hdl/qmix_checker.sv =====
// ----------------------------------------------------------------------------
// Quadrotor mixer checker
// Port-level assertions on handshake and result consistency.
// ----------------------------------------------------------------------------
module qmix_checker
  import qmix_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [SpdW-1:0]      speed_one,
  input logic [DutyW-1:0]     duty_front_right,
  input logic [NumMotors-1:0] saturated
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(speed_one)
      && $stable(duty_front_right) && $stable(saturated))
    else $error("result changed while stalled");

  // stall on the output blocks the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // a stopped motor one without saturation has zero duty
  a_zero_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && speed_one == '0 && !saturated[0] |-> duty_front_right == '0)
    else $error("nonzero duty at zero speed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");

endmodule

bind quadrotor_motor_mixer_core qmix_checker u_qmix_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .speed_one, .duty_front_right, .saturated
);

// ===== sim/quadrotor_motor_mixer_core_tb.sv =====
// ----------------------------------------------------------------------------
// Quadrotor motor mixer core testbench
// Drives random and corner-case thrust/torque commands through the valid/ready
// channels with random gaps and stalls, predicts speeds, duties and saturation
// flags per motor, and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module quadrotor_motor_mixer_core_tb
  import qmix_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [InW-1:0] thr;
    logic [InW-1:0] roll;
    logic [InW-1:0] pitch;
    logic [InW-1:0] yaw;
  } command_t;

  typedef struct packed {
    logic [DutyW-1:0]     duty1;
    logic [DutyW-1:0]     duty2;
    logic [DutyW-1:0]     duty3;
    logic [DutyW-1:0]     duty4;
    logic [SpdW-1:0]      spd1;
    logic [SpdW-1:0]      spd2;
    logic [SpdW-1:0]      spd3;
    logic [SpdW-1:0]      spd4;
    logic [NumMotors-1:0] sat;
  } motor_out_t;

  localparam int unsigned Latency = 22;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [InW-1:0] thrust = '0, roll_torque = '0, pitch_torque = '0, yaw_torque = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DutyW-1:0] duty_front_right, duty_rear_right, duty_rear_left, duty_front_left;
  logic [SpdW-1:0] speed_one, speed_two, speed_three, speed_four;
  logic [NumMotors-1:0] saturated;

  // model copy of the gain registers
  logic [GainW-1:0] g_thrust = '0, g_yaw = '0, g_tilt = '0, c_lin = '0;
  logic [QuadW-1:0] c_quad = '0;

  command_t   cmd_queue[$];
  motor_out_t mix_expected[$];
  int         mismatches = 0;
  int         send_wait = 0;
  int         recv_wait = 0;
  bit         hold_send = 1'b0;

  // handshakes as seen at the last rising edge
  logic in_ready_q = 1'b0;
  logic out_acc_q = 1'b0;

  quadrotor_motor_mixer_core i_dut (.*);

  always #4 clk = ~clk;

  function automatic logic [SpdW-1:0] int_sqrt(logic [SqW-1:0] v);
    logic [SpdW-1:0] r;
    logic [SpdW-1:0] t;
    r = '0;
    for (int b = SpdW - 1; b >= 0; b--) begin
      t = r | (16'd1 << b);
      if ({16'd0, t} * {16'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  function automatic motor_out_t mix_predict(command_t c);
    motor_out_t res;
    logic signed [SumW-1:0] tt, rr, pp, yy, m;
    logic [SqW-1:0] sq;
    logic [SpdW-1:0] s;
    logic [95:0] total;
    logic [15:0] d;
    logic [DutyW-1:0] duties[NumMotors];
    logic [SpdW-1:0] spds[NumMotors];
    logic sat;
    tt = $signed(c.thr) * $signed({1'b0, g_thrust});
    rr = $signed(c.roll) * $signed({1'b0, g_tilt});
    pp = $signed(c.pitch) * $signed({1'b0, g_tilt});
    yy = $signed(c.yaw) * $signed({1'b0, g_yaw});
    res = '0;
    for (int k = 0; k < NumMotors; k++) begin
      sat = 1'b0;
      m = tt + (NegPat[k][2] ? -yy : yy) + (NegPat[k][1] ? -rr : rr)
        + (NegPat[k][0] ? -pp : pp);
      if (m < 0) sq = '0;
      else if ((m >>> 24) > 67'sh0_FFFF_FFFF) begin
        sq = '1;
        sat = 1'b1;
      end else sq = m[55:24];
      s = int_sqrt(sq);
      total = {56'd0, c_quad} * ({80'd0, s} * {80'd0, s})
            + (({64'd0, c_lin} * {80'd0, s}) << 8);
      if (total > 96'hFF_FFFF_FFFF) begin
        d = 16'hFFFF;
        sat = 1'b1;
      end else d = total[39:24];
      duties[k] = d;
      spds[k] = s;
      res.sat[k] = sat;
    end
    res.duty1 = duties[0]; res.duty2 = duties[1];
    res.duty3 = duties[2]; res.duty4 = duties[3];
    res.spd1 = spds[0]; res.spd2 = spds[1]; res.spd3 = spds[2]; res.spd4 = spds[3];
    return res;
  endfunction

  // driver: predict at acceptance, pace with random gaps
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready_q) begin
        mix_expected.push_back(mix_predict({thrust, roll_torque, pitch_torque, yaw_torque}));
        cmd_queue.pop_front();
        send_wait = $urandom_range(0, 13);
      end
      if (!in_valid || in_ready_q) begin
        if (send_wait > 0 || hold_send || cmd_queue.size() == 0) begin
          in_valid <= 1'b0;
          if (send_wait > 0) send_wait--;
        end else begin
          in_valid <= 1'b1;
          {thrust, roll_torque, pitch_torque, yaw_torque} <= cmd_queue[0];
        end
      end
    end
  end

  always @(posedge clk) begin
    in_ready_q <= in_ready;
    out_acc_q  <= out_valid && out_ready;
  end

  // monitor
  always @(posedge clk) begin
    motor_out_t got, exp_res;
    if (!rst && out_valid && out_ready) begin
      got = '{duty_front_right, duty_rear_right, duty_rear_left, duty_front_left,
              speed_one, speed_two, speed_three, speed_four, saturated};
      if (mix_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_res = mix_expected.pop_front();
        if (got !== exp_res) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", exp_res, got);
        end
      end
    end
  end

  // receiver: draw a pause after every accepted result
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else begin
      if (out_acc_q) recv_wait = $urandom_range(0, 13);
      if (recv_wait > 0) begin
        out_ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return $urandom_range(0, 32'h00FF_FFFF);
      4: return -$urandom_range(0, 32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      RegThrustGain: g_thrust = val[31:0];
      RegYawGain:    g_yaw = val[31:0];
      RegTiltGain:   g_tilt = val[31:0];
      RegLinCoef:    c_lin = val[31:0];
      RegQuadCoef:   c_quad = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drain();
    while (cmd_queue.size() != 0 || in_valid || mix_expected.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  task automatic set_gains(int mode);
    case (mode)
      0: begin
        write_reg(RegThrustGain, 40'd1); write_reg(RegYawGain, 40'd1);
        write_reg(RegTiltGain, 40'd1); write_reg(RegLinCoef, 40'h1000_0000);
        write_reg(RegQuadCoef, 40'h00_0100_0000);
      end
      1: begin
        write_reg(RegThrustGain, 40'hFFFF_FFFF); write_reg(RegYawGain, 40'hFFFF_FFFF);
        write_reg(RegTiltGain, 40'hFFFF_FFFF); write_reg(RegLinCoef, 40'hFFFF_FFFF);
        write_reg(RegQuadCoef, 40'hFF_FFFF_FFFF);
      end
      2: begin
        write_reg(RegThrustGain, 40'd0); write_reg(RegYawGain, 40'd0);
        write_reg(RegTiltGain, 40'd0); write_reg(RegLinCoef, 40'd0);
        write_reg(RegQuadCoef, 40'd0);
      end
      default: begin
        write_reg(RegThrustGain, CfgDataW'($urandom_range(0, 4000)));
        write_reg(RegYawGain, CfgDataW'($urandom_range(0, 4000)));
        write_reg(RegTiltGain, CfgDataW'($urandom_range(0, 4000)));
        write_reg(RegLinCoef, CfgDataW'($urandom_range(0, 32'h0040_0000)));
        write_reg(RegQuadCoef, {8'($urandom_range(0, 3)),
                                32'($urandom_range(0, 32'h0010_0000))});
        // unknown index is ignored
        write_reg(3'd7, {8'hFF, 32'($urandom)});
      end
    endcase
  endtask

  initial begin
    command_t c;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: extremes and signs with small gains
    set_gains(0);
    cmd_queue.push_back('{32'h7FFF_FFFF, 0, 0, 0});
    cmd_queue.push_back('{32'h8000_0000, 0, 0, 0});
    cmd_queue.push_back('{0, 0, 0, 0});
    cmd_queue.push_back('{32'h0100_0000, 32'h0100_0000, 0, 0});
    cmd_queue.push_back('{32'h0100_0000, 0, 32'h0100_0000, 0});
    cmd_queue.push_back('{32'h0100_0000, 0, 0, 32'h0100_0000});
    cmd_queue.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    cmd_queue.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    cmd_queue.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    wait_drain();
    set_gains(1);
    cmd_queue.push_back('{32'h7FFF_FFFF, 0, 0, 0});
    cmd_queue.push_back('{32'h0000_0001, 0, 0, 0});
    cmd_queue.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    cmd_queue.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    wait_drain();
    set_gains(2);
    cmd_queue.push_back('{32'h7FFF_FFFF, 32'h1234_5678, 0, 0});
    wait_drain();
    // random phases
    for (int ph = 0; ph < 7; ph++) begin
      set_gains(ph == 3 ? 1 : 3);
      for (int i = 0; i < 100; i++) begin
        c = '{pick_word(), pick_word(), pick_word(), pick_word()};
        cmd_queue.push_back(c);
      end
      // hold off the sender mid-phase until everything is back
      while (cmd_queue.size() > 50) @(posedge clk);
      hold_send = 1'b1;
      while (in_valid || mix_expected.size() != 0) @(posedge clk);
      hold_send = 1'b0;
      wait_drain();
    end
    if (mismatches == 0) $display("[quadrotor_motor_mixer_core] OK");
    else $display("[quadrotor_motor_mixer_core] ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("[quadrotor_motor_mixer_core] ERROR");
    $finish;
  end

endmodule

// ===== quadrotor_motor_mixer_core.f =====
hdl/qmix_pkg.sv
hdl/quadrotor_motor_mixer_core.sv
hdl/qmix_checker.sv
sim/quadrotor_motor_mixer_core_tb.sv
